// ===== hw/rtl/tlbpt_pkg.sv =====
// shared constants and types for the tlb page table translator
`timescale 1ns / 1ps
package tlbpt_pkg;

  localparam int VA_W   = 16;
  localparam int PA_W   = 16;
  localparam int OFF_W  = 8;
  localparam int PN_W   = 8;
  localparam int FN_W   = 8;
  localparam int CNT_W  = 32;
  localparam int PAGE_CNT  = 1 << PN_W;
  localparam int FRAME_CNT = 1 << FN_W;

  localparam logic [1:0] OUTCOME_TLB_HIT = 2'd0;
  localparam logic [1:0] OUTCOME_PT_HIT  = 2'd1;
  localparam logic [1:0] OUTCOME_FAULT   = 2'd2;

  typedef struct packed {
    logic [PN_W-1:0]  page;
    logic [OFF_W-1:0] offset;
  } tlbpt_item_t;

endpackage

// ===== hw/rtl/tlbpt_front.sv =====
// front stage: takes a virtual address word and splits it into page and offset
`timescale 1ns / 1ps
module tlbpt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          in_virtual_address,
  output logic                 push_valid,
  input  logic                 push_full,
  output tlbpt_pkg::tlbpt_item_t push_item
);
  import tlbpt_pkg::*;

  logic        stage_valid_r;
  tlbpt_item_t stage_item_r;

  assign push_valid = stage_valid_r;
  assign push_item  = stage_item_r;
  assign in_stall   = stage_valid_r && push_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (!in_stall) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_item_r.page   <= in_virtual_address[OFF_W +: PN_W];
      stage_item_r.offset <= in_virtual_address[OFF_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/tlbpt_queue.sv =====
// two entry queue between the front stage and the translation engine
`timescale 1ns / 1ps
module tlbpt_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_valid,
  output logic                   push_full,
  input  tlbpt_pkg::tlbpt_item_t push_item,
  output logic                   pop_valid,
  input  logic                   pop,
  output tlbpt_pkg::tlbpt_item_t pop_item
);
  import tlbpt_pkg::*;

  tlbpt_item_t slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign push_full = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

// ===== hw/rtl/tlbpt_back.sv =====
// translation engine: tlb, page table, frame lru list and result register
`timescale 1ns / 1ps
module tlbpt_back #(
  parameter int TLB_SIZE = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  tlbpt_pkg::tlbpt_item_t q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            out_physical_address,
  output logic [7:0]             out_frame_number,
  output logic [1:0]             out_outcome,
  output logic [7:0]             out_fill_page,
  output logic                   out_evicted,
  output logic [7:0]             out_evicted_page,
  output logic [31:0]            out_tlb_hit_total,
  output logic [31:0]            out_fault_total,
  output logic [31:0]            out_address_total
);
  import tlbpt_pkg::*;

  localparam int TW = (TLB_SIZE > 1) ? $clog2(TLB_SIZE) : 1;
  localparam logic [TW-1:0] TOP_RANK = TW'(TLB_SIZE - 1);

  localparam logic [3:0] S_LOOK = 4'd0;
  localparam logic [3:0] S_PT   = 4'd1;
  localparam logic [3:0] S_EV   = 4'd2;
  localparam logic [3:0] S_INST = 4'd3;
  localparam logic [3:0] S_TRD  = 4'd4;
  localparam logic [3:0] S_TA   = 4'd5;
  localparam logic [3:0] S_TB   = 4'd6;
  localparam logic [3:0] S_APP  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  typedef logic [TLB_SIZE-1:0][TW-1:0] rank_vec_t;

  logic [3:0] state_r, state_nxt;

  // tlb
  logic [TLB_SIZE-1:0]           tv_r;
  logic [TLB_SIZE-1:0][PN_W-1:0] tt_r;
  logic [TLB_SIZE-1:0][FN_W-1:0] tf_r;
  rank_vec_t                     trk_r;

  // page table valid bits and memories
  logic [PAGE_CNT-1:0] pv_r;
  logic [FN_W-1:0] page_map_m [PAGE_CNT];
  logic [PN_W-1:0] owner_m    [FRAME_CNT];
  logic [FN_W-1:0] nxt_m      [FRAME_CNT];
  logic [FN_W-1:0] prv_m      [FRAME_CNT];
  logic [FN_W-1:0] pm_rd_r;
  logic [PN_W-1:0] owner_rd_r;
  logic [FN_W-1:0] nxt_rd_r;
  logic [FN_W-1:0] prv_rd_r;

  logic [FN_W:0]   next_unused_r;
  logic [FN_W-1:0] head_r;
  logic [FN_W-1:0] tail_r;
  logic [FN_W-1:0] frame_r;
  logic [1:0]      outcome_r;
  logic            ev_r;
  logic [PN_W-1:0] ev_page_r;
  logic            new_frame_r;

  logic [CNT_W-1:0] hit_cnt_r, fault_cnt_r, acc_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt, fault_cnt_nxt, acc_cnt_nxt;

  logic            out_valid_r;
  logic [PA_W-1:0] o_pa_r;
  logic [FN_W-1:0] o_fn_r;
  logic [1:0]      o_oc_r;
  logic [PN_W-1:0] o_fill_r;
  logic            o_ev_r;
  logic [PN_W-1:0] o_evp_r;
  logic [CNT_W-1:0] o_hit_r, o_fault_r, o_acc_r;

  logic          tlb_hit;
  logic [TW-1:0] hit_idx;
  logic          slot_found;
  logic [TW-1:0] slot_idx;
  logic          all_used;
  logic          go;
  logic          out_free;
  logic          first_frame;
  logic [FN_W+OFF_W-1:0] pa_full;

  function automatic rank_vec_t make_recent(input rank_vec_t rk, input logic [TW-1:0] idx);
    rank_vec_t res;
    logic [TW-1:0] r;
    res = rk;
    r = rk[idx];
    for (int i = 0; i < TLB_SIZE; i++) begin
      if (rk[i] > r) res[i] = rk[i] - 1'b1;
    end
    res[idx] = TOP_RANK;
    return res;
  endfunction

  always_comb begin
    tlb_hit = 1'b0;
    hit_idx = '0;
    slot_found = 1'b0;
    slot_idx = '0;
    for (int i = 0; i < TLB_SIZE; i++) begin
      if (!tlb_hit && tv_r[i] && tt_r[i] == q_item.page) begin
        tlb_hit = 1'b1;
        hit_idx = TW'(i);
      end
      if (!slot_found && trk_r[i] == '0) begin
        slot_found = 1'b1;
        slot_idx = TW'(i);
      end
    end
  end

  assign all_used    = next_unused_r[FN_W];
  assign go          = q_valid;
  assign out_free    = !out_valid_r || !out_stall;
  assign q_pop       = (state_r == S_DONE) && out_free;
  assign first_frame = (next_unused_r == {{FN_W{1'b0}}, 1'b1});
  assign pa_full     = {frame_r, q_item.offset};

  assign hit_cnt_nxt   = hit_cnt_r + ((outcome_r == OUTCOME_TLB_HIT) ? 1 : 0);
  assign fault_cnt_nxt = fault_cnt_r + ((outcome_r == OUTCOME_FAULT) ? 1 : 0);
  assign acc_cnt_nxt   = acc_cnt_r + 1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOOK: begin
        if (go) begin
          if (tlb_hit) state_nxt = S_TRD;
          else if (pv_r[q_item.page]) state_nxt = S_PT;
          else if (all_used) state_nxt = S_EV;
          else state_nxt = S_INST;
        end
      end
      S_PT:   state_nxt = S_INST;
      S_EV:   state_nxt = S_INST;
      S_INST: state_nxt = new_frame_r ? S_APP : S_TRD;
      S_TRD:  state_nxt = (frame_r == tail_r) ? S_DONE : S_TA;
      S_TA:   state_nxt = S_TB;
      S_TB:   state_nxt = S_DONE;
      S_APP:  state_nxt = S_DONE;
      S_DONE: state_nxt = out_free ? S_LOOK : S_DONE;
      default: state_nxt = S_LOOK;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOOK;
      tv_r          <= '0;
      pv_r          <= '0;
      next_unused_r <= '0;
      hit_cnt_r     <= '0;
      fault_cnt_r   <= '0;
      acc_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < TLB_SIZE; i++) trk_r[i] <= TW'(i);
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_LOOK: begin
          if (go) begin
            if (tlb_hit) begin
              trk_r <= make_recent(trk_r, hit_idx);
            end else if (!pv_r[q_item.page] && !all_used) begin
              pv_r[q_item.page] <= 1'b1;
              next_unused_r <= next_unused_r + 1'b1;
            end
          end
        end
        S_EV: begin
          pv_r[owner_rd_r] <= 1'b0;
          pv_r[q_item.page] <= 1'b1;
          for (int i = 0; i < TLB_SIZE; i++) begin
            if (tv_r[i] && tt_r[i] == owner_rd_r) tv_r[i] <= 1'b0;
          end
        end
        S_INST: begin
          tv_r[slot_idx] <= 1'b1;
          trk_r <= make_recent(trk_r, slot_idx);
        end
        S_DONE: begin
          if (out_free) begin
            hit_cnt_r   <= hit_cnt_nxt;
            fault_cnt_r <= fault_cnt_nxt;
            acc_cnt_r   <= acc_cnt_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_LOOK: begin
        ev_r <= 1'b0;
        ev_page_r <= '0;
        new_frame_r <= 1'b0;
        if (tlb_hit) begin
          frame_r <= tf_r[hit_idx];
          outcome_r <= OUTCOME_TLB_HIT;
        end else if (pv_r[q_item.page]) begin
          outcome_r <= OUTCOME_PT_HIT;
        end else if (all_used) begin
          frame_r <= head_r;
          outcome_r <= OUTCOME_FAULT;
        end else begin
          frame_r <= next_unused_r[FN_W-1:0];
          outcome_r <= OUTCOME_FAULT;
          new_frame_r <= 1'b1;
        end
      end
      S_PT: frame_r <= pm_rd_r;
      S_EV: begin
        ev_r <= 1'b1;
        ev_page_r <= owner_rd_r;
      end
      S_INST: begin
        tt_r[slot_idx] <= q_item.page;
        tf_r[slot_idx] <= frame_r;
      end
      S_TA: begin
        if (frame_r == head_r) head_r <= nxt_rd_r;
      end
      S_TB: tail_r <= frame_r;
      S_APP: begin
        if (first_frame) head_r <= frame_r;
        tail_r <= frame_r;
      end
      S_DONE: begin
        if (out_free) begin
          o_pa_r    <= pa_full[PA_W-1:0];
          o_fn_r    <= frame_r;
          o_oc_r    <= outcome_r;
          o_fill_r  <= (outcome_r == OUTCOME_FAULT) ? q_item.page : '0;
          o_ev_r    <= ev_r;
          o_evp_r   <= ev_page_r;
          o_hit_r   <= hit_cnt_nxt;
          o_fault_r <= fault_cnt_nxt;
          o_acc_r   <= acc_cnt_nxt;
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    pm_rd_r    <= page_map_m[q_item.page];
    owner_rd_r <= owner_m[head_r];
    nxt_rd_r   <= nxt_m[frame_r];
    prv_rd_r   <= prv_m[frame_r];
    if ((state_r == S_LOOK && go && !tlb_hit && !pv_r[q_item.page] && !all_used)) begin
      page_map_m[q_item.page] <= next_unused_r[FN_W-1:0];
      owner_m[next_unused_r[FN_W-1:0]] <= q_item.page;
    end
    if (state_r == S_EV) begin
      page_map_m[q_item.page] <= frame_r;
      owner_m[frame_r] <= q_item.page;
    end
    if (state_r == S_TA) begin
      if (frame_r != head_r) nxt_m[prv_rd_r] <= nxt_rd_r;
      prv_m[nxt_rd_r] <= prv_rd_r;
    end
    if (state_r == S_TB || (state_r == S_APP && !first_frame)) begin
      nxt_m[tail_r] <= frame_r;
      prv_m[frame_r] <= tail_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = o_pa_r;
  assign out_frame_number     = o_fn_r;
  assign out_outcome          = o_oc_r;
  assign out_fill_page        = o_fill_r;
  assign out_evicted          = o_ev_r;
  assign out_evicted_page     = o_evp_r;
  assign out_tlb_hit_total    = o_hit_r;
  assign out_fault_total      = o_fault_r;
  assign out_address_total    = o_acc_r;

endmodule

// ===== hw/rtl/tlb_page_table_lru_translator_core.sv =====
// top level of the demand paging translator with lru tlb and frame replacement
// path: a tlb hit runs S_LOOK, S_TRD and, unless its frame is already the most recent
// frame, S_TA and S_TB before S_DONE; a page table hit adds S_PT and S_INST after S_LOOK,
// an eviction fault adds S_EV and S_INST, and a fault into a never-used frame runs S_LOOK,
// S_INST and S_APP before S_DONE, after the front stage register and queue; the engine takes
// a new word only from S_DONE, which holds while the output is stalled
// reset: synchronous active-low rst_n clears valid bits and counters and sets lru ranks to slot order at once
`timescale 1ns / 1ps
module tlb_page_table_lru_translator_core #(
  parameter int TLB_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_virtual_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_physical_address,
  output logic [7:0]  out_frame_number,
  output logic [1:0]  out_outcome,
  output logic [7:0]  out_fill_page,
  output logic        out_evicted,
  output logic [7:0]  out_evicted_page,
  output logic [31:0] out_tlb_hit_total,
  output logic [31:0] out_fault_total,
  output logic [31:0] out_address_total
);
  import tlbpt_pkg::*;

  logic        push_valid;
  logic        push_full;
  tlbpt_item_t push_item;
  logic        pop_valid;
  logic        pop;
  tlbpt_item_t pop_item;

  tlbpt_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_virtual_address (in_virtual_address),
    .push_valid         (push_valid),
    .push_full          (push_full),
    .push_item          (push_item)
  );

  tlbpt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  tlbpt_back #(
    .TLB_SIZE (TLB_SIZE)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (pop_valid),
    .q_item               (pop_item),
    .q_pop                (pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_physical_address (out_physical_address),
    .out_frame_number     (out_frame_number),
    .out_outcome          (out_outcome),
    .out_fill_page        (out_fill_page),
    .out_evicted          (out_evicted),
    .out_evicted_page     (out_evicted_page),
    .out_tlb_hit_total    (out_tlb_hit_total),
    .out_fault_total      (out_fault_total),
    .out_address_total    (out_address_total)
  );

endmodule
